/* src/nblc_pkg.sv */
// Package with shared widths, result codes and box helper functions.
`timescale 1ns / 1ps
`default_nettype none
package nblc_pkg;

    localparam int DIM_W = 16;
    localparam int KEY_W = 3 * DIM_W;
    localparam int VAL_W = 6;

    // Result word kinds.
    localparam logic KIND_LENGTH = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

    typedef logic [KEY_W-1:0] key_t;

    // Sort three dimensions ascending and pack the smallest into the top bits.
    function automatic key_t make_key(input logic [DIM_W-1:0] a_in,
                                      input logic [DIM_W-1:0] b_in,
                                      input logic [DIM_W-1:0] c_in);
        logic [DIM_W-1:0] a;
        logic [DIM_W-1:0] b;
        logic [DIM_W-1:0] c;
        logic [DIM_W-1:0] t;
        a = a_in;
        b = b_in;
        c = c_in;
        if (a > b)
        begin
            t = a; a = b; b = t;
        end
        if (b > c)
        begin
            t = b; b = c; c = t;
        end
        if (a > b)
        begin
            t = a; a = b; b = t;
        end
        return {a, b, c};
    endfunction

    // True when every dimension of the inner box is strictly smaller.
    function automatic logic nests_inside(input key_t inner, input key_t outer);
        return (inner[KEY_W-1:2*DIM_W] < outer[KEY_W-1:2*DIM_W]) &&
               (inner[2*DIM_W-1:DIM_W] < outer[2*DIM_W-1:DIM_W]) &&
               (inner[DIM_W-1:0] < outer[DIM_W-1:0]);
    endfunction

endpackage
`default_nettype wire

/* src/nblc_if.sv */
// Channel interfaces for the box input and the result output.
`timescale 1ns / 1ps
`default_nettype none
interface nblc_box_if
    import nblc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [DIM_W-1:0] dim_first;
    logic [DIM_W-1:0] dim_second;
    logic [DIM_W-1:0] dim_third;
    logic             last_box;

    modport source (output valid, dim_first, dim_second, dim_third, last_box,
                    input ready);
    modport sink (input valid, dim_first, dim_second, dim_third, last_box,
                  output ready);
endinterface

interface nblc_result_if
    import nblc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             result_kind;
    logic [VAL_W-1:0] result_value;
    logic             last_result;

    modport source (output valid, result_kind, result_value, last_result,
                    input ready);
    modport sink (input valid, result_kind, result_value, last_result,
                  output ready);
endinterface
`default_nettype wire

/* src/nested_box_longest_chain.sv */
// Longest strictly nested box chain finder built around small synchronous memories.
//
// The in_box channel takes one box word per handshake. Boxes are inserted in
// sorted order as they arrive; the word with last_box set closes the set.
// The out_res channel then delivers a length word followed by the original
// indices of the chain, outermost box first; last_result marks the final one.
// Insertion reads and shifts one box at a time, from the end of the sorted
// list downward, until the new box can be placed; the box memory has a single
// read port. The chain search reads the candidates below each outer box one
// at a time, and each index word waits for a read of the origin and link
// memories. in_box is ready only while the block waits for boxes, so no new
// box is taken during insertion, the chain search or the chain walk.
// Reset clears the box count and returns the block to waiting for boxes; the
// memories are not cleared, since every entry is written before it is read.
// When the receiver stalls, the current word waits in the output register and
// the length output or chain walk holds. Boxes beyond MAX_BOXES are dropped,
// though their last_box mark still starts the search.
`timescale 1ns / 1ps
`default_nettype none
module nested_box_longest_chain
    import nblc_pkg::*;
#(
    parameter int MAX_BOXES = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    nblc_box_if.sink         in_box,
    nblc_result_if.source    out_res
);

    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);

    localparam logic [3:0] S_LOAD    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;
    localparam logic [3:0] S_INS_CMP = 4'd2;
    localparam logic [3:0] S_DP_INIT = 4'd3;
    localparam logic [3:0] S_DP_I    = 4'd4;
    localparam logic [3:0] S_DP_IW   = 4'd5;
    localparam logic [3:0] S_DP_K    = 4'd6;
    localparam logic [3:0] S_DP_KW   = 4'd7;
    localparam logic [3:0] S_OUT_LEN = 4'd8;
    localparam logic [3:0] S_OUT_RD  = 4'd9;
    localparam logic [3:0] S_OUT_W   = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    key_t             key_reg, key_next;
    logic [CW-1:0]    p_reg, p_next;
    logic             last_reg, last_next;
    logic [CW-1:0]    i_reg, i_next;
    logic [CW-1:0]    k_reg, k_next;
    key_t             boxi_reg, boxi_next;
    logic [VAL_W-1:0] len_reg, len_next;
    logic [AW-1:0]    pred_reg, pred_next;
    logic [VAL_W-1:0] best_reg, best_next;
    logic [AW-1:0]    top_reg, top_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [VAL_W-1:0] emit_reg, emit_next;

    logic             ovalid_reg, ovalid_next;
    logic             okind_reg, okind_next;
    logic [VAL_W-1:0] oval_reg, oval_next;
    logic             olast_reg, olast_next;

    // Memory ports.
    logic             box_we;
    logic [AW-1:0]    box_wa;
    key_t             box_wd;
    logic [VAL_W-1:0] org_wd;
    logic             dp_we;
    logic [AW-1:0]    rd_addr;
    key_t             rd_box;
    logic [VAL_W-1:0] rd_org;
    logic [VAL_W-1:0] rd_len;
    logic [AW-1:0]    rd_pred;

    key_t             box_mem [MAX_BOXES];
    logic [VAL_W-1:0] org_mem [MAX_BOXES];
    logic [VAL_W-1:0] len_mem [MAX_BOXES];
    logic [AW-1:0]    pred_mem [MAX_BOXES];

    logic in_acc;
    logic out_free;
    key_t in_key;

    assign in_box.ready = (state_reg == S_LOAD);
    assign in_acc       = in_box.valid && in_box.ready;
    assign out_free     = !ovalid_reg || out_res.ready;
    assign in_key       = make_key(in_box.dim_first, in_box.dim_second, in_box.dim_third);

    assign out_res.valid        = ovalid_reg;
    assign out_res.result_kind  = okind_reg;
    assign out_res.result_value = oval_reg;
    assign out_res.last_result  = olast_reg;

    // Box and origin memories share their addresses.
    always_ff @(posedge clk)
    begin
        if (box_we)
        begin
            box_mem[box_wa] <= box_wd;
            org_mem[box_wa] <= org_wd;
        end
        rd_box <= box_mem[rd_addr];
        rd_org <= org_mem[rd_addr];
    end

    // Chain length and link memories, written at the current outer box.
    always_ff @(posedge clk)
    begin
        if (dp_we)
        begin
            len_mem[i_reg[AW-1:0]]  <= len_reg;
            pred_mem[i_reg[AW-1:0]] <= pred_reg;
        end
        rd_len  <= len_mem[rd_addr];
        rd_pred <= pred_mem[rd_addr];
    end

    // Sequencer for insertion, chain search and chain walk.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        p_next      = p_reg;
        last_next   = last_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        boxi_next   = boxi_reg;
        len_next    = len_reg;
        pred_next   = pred_reg;
        best_next   = best_reg;
        top_next    = top_reg;
        pos_next    = pos_reg;
        emit_next   = emit_reg;
        ovalid_next = ovalid_reg && !out_res.ready;
        okind_next  = okind_reg;
        oval_next   = oval_reg;
        olast_next  = olast_reg;
        box_we      = 1'b0;
        box_wa      = p_reg[AW-1:0];
        box_wd      = key_reg;
        org_wd      = VAL_W'(cnt_reg);
        dp_we       = 1'b0;
        rd_addr     = '0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (cnt_reg < CW'(MAX_BOXES))
                    begin
                        key_next   = in_key;
                        p_next     = cnt_reg;
                        last_next  = in_box.last_box;
                        state_next = S_INS_RD;
                    end
                    else if (in_box.last_box)
                    begin
                        state_next = S_DP_INIT;
                    end
                end
            end
            S_INS_RD:
            begin
                if (p_reg == '0)
                begin
                    box_we     = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = last_reg ? S_DP_INIT : S_LOAD;
                end
                else
                begin
                    rd_addr    = AW'(p_reg - 1'b1);
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                box_we = 1'b1;
                if (rd_box > key_reg)
                begin
                    box_wd     = rd_box;
                    org_wd     = rd_org;
                    p_next     = p_reg - 1'b1;
                    state_next = S_INS_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = last_reg ? S_DP_INIT : S_LOAD;
                end
            end
            S_DP_INIT:
            begin
                best_next  = VAL_W'(1);
                top_next   = '0;
                i_next     = '0;
                state_next = S_DP_I;
            end
            S_DP_I:
            begin
                if (i_reg == cnt_reg)
                begin
                    state_next = S_OUT_LEN;
                end
                else
                begin
                    rd_addr    = i_reg[AW-1:0];
                    state_next = S_DP_IW;
                end
            end
            S_DP_IW:
            begin
                boxi_next  = rd_box;
                len_next   = VAL_W'(1);
                pred_next  = i_reg[AW-1:0];
                k_next     = i_reg;
                state_next = S_DP_K;
            end
            S_DP_K:
            begin
                if (k_reg == '0)
                begin
                    dp_we = 1'b1;
                    if (len_reg > best_reg)
                    begin
                        best_next = len_reg;
                        top_next  = i_reg[AW-1:0];
                    end
                    i_next     = i_reg + 1'b1;
                    state_next = S_DP_I;
                end
                else
                begin
                    rd_addr    = AW'(k_reg - 1'b1);
                    state_next = S_DP_KW;
                end
            end
            S_DP_KW:
            begin
                // Higher positions win ties: the scan runs downward and len_reg <= rd_len takes only a longer chain.
                if (nests_inside(rd_box, boxi_reg) && (len_reg <= rd_len))
                begin
                    pred_next = AW'(k_reg - 1'b1);
                    len_next  = rd_len + 1'b1;
                end
                k_next     = k_reg - 1'b1;
                state_next = S_DP_K;
            end
            S_OUT_LEN:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = KIND_LENGTH;
                    oval_next   = best_reg;
                    olast_next  = 1'b0;
                    pos_next    = top_reg;
                    emit_next   = '0;
                    state_next  = S_OUT_RD;
                end
            end
            S_OUT_RD:
            begin
                rd_addr    = pos_reg;
                state_next = S_OUT_W;
            end
            S_OUT_W:
            begin
                // Keep reading the same entry so the data holds while the receiver stalls.
                rd_addr = pos_reg;
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = KIND_INDEX;
                    oval_next   = rd_org;
                    olast_next  = (emit_reg + 1'b1 == best_reg);
                    pos_next    = rd_pred;
                    emit_next   = emit_reg + 1'b1;
                    if (emit_reg + 1'b1 == best_reg)
                    begin
                        cnt_next   = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            cnt_reg    <= '0;
            best_reg   <= '0;
            top_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            best_reg   <= best_next;
            top_reg    <= top_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        p_reg     <= p_next;
        last_reg  <= last_next;
        i_reg     <= i_next;
        k_reg     <= k_next;
        boxi_reg  <= boxi_next;
        len_reg   <= len_next;
        pred_reg  <= pred_next;
        pos_reg   <= pos_next;
        emit_reg  <= emit_next;
        okind_reg <= okind_next;
        oval_reg  <= oval_next;
        olast_reg <= olast_next;
    end

    // The stored box count never exceeds capacity.
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_BOXES))
        else $error("box count above capacity");

    // The final word of a run is always an index word.
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && olast_reg |-> okind_reg == KIND_INDEX)
        else $error("last word is not an index");

    // Every insertion compare writes the box memory, either a shifted box or the new one.
    a_ins_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS_CMP |-> box_we)
        else $error("insertion compare without write");

    // A completed chain walk returns the block to loading with an empty set.
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT_W && out_free && emit_reg + 1'b1 == best_reg
        |=> state_reg == S_LOAD && cnt_reg == '0)
        else $error("run did not end cleanly");

endmodule
`default_nettype wire
